>>> rtl/cpu8_register_alu_execute_macros.svh
// Assertion macros for the execute block
`ifndef CPU8_REGISTER_ALU_EXECUTE_MACROS_SVH
`define CPU8_REGISTER_ALU_EXECUTE_MACROS_SVH
`ifndef ASSERT_OFF
`define CPU8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CPU8_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CPU8_ASSERT(lbl, prop, msg)
`define CPU8_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> rtl/cpu8_pkg.sv
// Shared types and constants of the execute block
package cpu8_pkg;

  localparam logic [7:0] FLAG_C = 8'h01;
  localparam logic [7:0] FLAG_Z = 8'h02;
  localparam logic [7:0] FLAG_I = 8'h04;
  localparam logic [7:0] FLAG_D = 8'h08;
  localparam logic [7:0] FLAG_B = 8'h10;
  localparam logic [7:0] FLAG_U = 8'h20;
  localparam logic [7:0] FLAG_V = 8'h40;
  localparam logic [7:0] FLAG_N = 8'h80;

  localparam logic [7:0] RESET_SP     = 8'hFD;
  localparam logic [7:0] RESET_STATUS = 8'h24;
  localparam logic [7:0] RESET_MAGIC  = 8'hEE;

  // Opcode column groups
  localparam logic [1:0] CC_CTRL  = 2'd0;
  localparam logic [1:0] CC_ALU   = 2'd1;
  localparam logic [1:0] CC_RMW   = 2'd2;
  localparam logic [1:0] CC_ILLEG = 2'd3;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand;
    logic [7:0] address_high;
  } insn_t;

  // Decoded instruction handed from front to back
  typedef struct packed {
    logic [1:0] cc;
    logic [2:0] aaa;
    logic [2:0] bbb;
    logic [7:0] operand;
    logic [7:0] hp1;
  } dec_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] status_out;
    logic       mem_write;
    logic [7:0] write_data;
    logic       branch_taken;
  } result_t;

endpackage

>>> rtl/cpu8_stream_if.sv
// Valid/ready channel carrying one payload
interface cpu8_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cpu8_front.sv
// Front part: accept instructions, classify opcode fields
module cpu8_front
  import cpu8_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  insn_t in_data_i,
  output logic  dec_valid_o,
  input  logic  dec_ready_i,
  output dec_t  dec_data_o
);
  logic valid_q, valid_d;
  dec_t data_q;

  assign in_ready_o  = !valid_q || dec_ready_i;
  assign dec_valid_o = valid_q;
  assign dec_data_o  = data_q;

  // Advance the decode register whenever it drains
  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) valid_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q.cc      <= in_data_i.opcode[1:0];
      data_q.bbb     <= in_data_i.opcode[4:2];
      data_q.aaa     <= in_data_i.opcode[7:5];
      data_q.operand <= in_data_i.operand;
      data_q.hp1     <= in_data_i.address_high + 8'd1;
    end
  end
endmodule

>>> rtl/cpu8_queue.sv
// Two-entry queue between the front and the back
module cpu8_queue
  import cpu8_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  dec_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output dec_t rd_data_o
);
  dec_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rptr_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  // Move pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_data_i;
  end
endmodule

>>> rtl/cpu8_back.sv
// Back part: execute a decoded instruction on the register file
module cpu8_back
  import cpu8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       dec_valid_i,
  output logic       dec_ready_o,
  input  dec_t       dec_data_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_data_o
);
`include "cpu8_register_alu_execute_macros.svh"

  logic [7:0] a_q, x_q, y_q, sp_q, p_q, magic_q;
  logic [7:0] a_d, x_d, y_d, sp_d, p_d;
  logic       out_valid_q;
  result_t    out_q;
  logic       fire;
  logic       wr;
  logic [7:0] wd;
  logic       br;

  assign dec_ready_o = !out_valid_q || res_ready_i;
  assign fire        = dec_valid_i && dec_ready_o;
  assign res_valid_o = out_valid_q;
  assign res_data_o  = out_q;

  // Shift unit: ASL, ROL, LSR, ROR
  function automatic void shift(input logic [1:0] kind, input logic [7:0] val,
                                input logic [7:0] pin, output logic [7:0] res,
                                output logic [7:0] pout);
    pout = pin;
    unique case (kind)
      2'd0: begin res = {val[6:0], 1'b0}; pout[0] = val[7]; end
      2'd1: begin res = {val[6:0], pin[0]}; pout[0] = val[7]; end
      2'd2: begin res = {1'b0, val[7:1]}; pout[0] = val[0]; end
      default: begin res = {pin[0], val[7:1]}; pout[0] = val[0]; end
    endcase
    pout[7] = res[7];
    pout[1] = res == 8'd0;
  endfunction

  // Accumulator group: ORA AND EOR ADC - LDA CMP SBC
  function automatic void alu(input logic [2:0] kind, input logic [7:0] val,
                              input logic [7:0] ain, input logic [7:0] pin,
                              output logic [7:0] aout, output logic [7:0] pout);
    logic [7:0] b;
    logic [8:0] sum;
    logic [7:0] diff;
    b = (kind == 3'd7) ? ~val : val;
    sum = {1'b0, ain} + {1'b0, b} + {8'd0, pin[0]};
    diff = ain - val;
    pout = pin;
    aout = ain;
    unique case (kind)
      3'd0: aout = ain | val;
      3'd1: aout = ain & val;
      3'd2: aout = ain ^ val;
      3'd3, 3'd7: begin
        aout = sum[7:0]; pout[0] = sum[8];
        pout[6] = (ain[7] ^ sum[7]) & (b[7] ^ sum[7]);
      end
      3'd5: aout = val;
      3'd6: begin
        pout[0] = ain >= val; pout[7] = diff[7];
        pout[1] = ain == val;
      end
      default: ;
    endcase
    if (kind != 3'd4 && kind != 3'd6) begin
      pout[7] = aout[7]; pout[1] = aout == 8'd0;
    end
  endfunction

  // Execute one instruction
  always_comb begin
    logic [1:0] cc;
    logic [2:0] aaa, bbb;
    logic [7:0] m, hp1, r, v;
    logic       plain, flg;
    cc = dec_data_i.cc;
    aaa = dec_data_i.aaa;
    bbb = dec_data_i.bbb;
    m = dec_data_i.operand;
    hp1 = dec_data_i.hp1;
    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
    wr = 1'b0; wd = 8'd0; br = 1'b0;
    r = 8'd0; v = 8'd0; flg = 1'b0;
    plain = (bbb == 3'd1) || (bbb == 3'd3);
    unique case (cc)
      CC_CTRL: begin
        if (bbb == 3'd4) begin
          unique case (aaa[2:1])
            2'd0: flg = p_q[7];
            2'd1: flg = p_q[6];
            2'd2: flg = p_q[0];
            default: flg = p_q[1];
          endcase
          br = flg == aaa[0];
        end else if (bbb == 3'd6) begin
          unique case (aaa)
            3'd0: p_d[0] = 1'b0;
            3'd1: p_d[0] = 1'b1;
            3'd2: p_d[2] = 1'b0;
            3'd3: p_d[2] = 1'b1;
            3'd4: begin a_d = y_q; p_d[7] = y_q[7]; p_d[1] = y_q == 8'd0; end
            3'd5: p_d[6] = 1'b0;
            3'd6: p_d[3] = 1'b0;
            default: p_d[3] = 1'b1;
          endcase
        end else if (bbb == 3'd2) begin
          unique case (aaa)
            3'd0: begin wr = 1'b1; wd = p_q | FLAG_B | FLAG_U; sp_d = sp_q - 8'd1; end
            3'd1: begin sp_d = sp_q + 8'd1; p_d = (m & 8'hCF) | FLAG_U; end
            3'd2: begin wr = 1'b1; wd = a_q; sp_d = sp_q - 8'd1; end
            3'd3: begin sp_d = sp_q + 8'd1; a_d = m; p_d[7] = m[7]; p_d[1] = m == 8'd0; end
            3'd4: y_d = y_q - 8'd1;
            3'd5: y_d = a_q;
            3'd6: y_d = y_q + 8'd1;
            default: x_d = x_q + 8'd1;
          endcase
          if (aaa == 3'd4 || aaa == 3'd5 || aaa == 3'd6) begin
            p_d[7] = y_d[7]; p_d[1] = y_d == 8'd0;
          end else if (aaa == 3'd7) begin
            p_d[7] = x_d[7]; p_d[1] = x_d == 8'd0;
          end
        end else if (bbb == 3'd0) begin
          unique case (aaa)
            3'd0: begin sp_d = sp_q - 8'd3; p_d[2] = 1'b1; end
            3'd1: sp_d = sp_q - 8'd2;
            3'd2: begin sp_d = sp_q + 8'd3; p_d = (m & 8'hCF) | FLAG_U; end
            3'd3: sp_d = sp_q + 8'd2;
            3'd5: begin y_d = m; p_d[7] = m[7]; p_d[1] = m == 8'd0; end
            3'd6: begin r = y_q - m; p_d[0] = y_q >= m; p_d[7] = r[7]; p_d[1] = r == 8'd0; end
            3'd7: begin r = x_q - m; p_d[0] = x_q >= m; p_d[7] = r[7]; p_d[1] = r == 8'd0; end
            default: ;
          endcase
        end else begin
          unique case (aaa)
            3'd1: if (plain) begin
              p_d[1] = (a_q & m) == 8'd0; p_d[7] = m[7]; p_d[6] = m[6];
            end
            3'd4: begin wr = 1'b1; wd = (bbb == 3'd7) ? (y_q & hp1) : y_q; end
            3'd5: begin y_d = m; p_d[7] = m[7]; p_d[1] = m == 8'd0; end
            3'd6: if (plain) begin
              r = y_q - m; p_d[0] = y_q >= m; p_d[7] = r[7]; p_d[1] = r == 8'd0;
            end
            3'd7: if (plain) begin
              r = x_q - m; p_d[0] = x_q >= m; p_d[7] = r[7]; p_d[1] = r == 8'd0;
            end
            default: ;
          endcase
        end
      end
      CC_ALU: begin
        if (aaa == 3'd4) begin
          if (bbb != 3'd2) begin wr = 1'b1; wd = a_q; end
        end else begin
          alu(aaa, m, a_q, p_q, a_d, p_d);
        end
      end
      CC_RMW: begin
        if (bbb == 3'd4 || (bbb == 3'd0 && !aaa[2])) begin
          // jam: hold everything
        end else if (bbb == 3'd0) begin
          if (aaa == 3'd5) begin x_d = m; p_d[7] = m[7]; p_d[1] = m == 8'd0; end
        end else if (bbb == 3'd2) begin
          if (!aaa[2]) shift(aaa[1:0], a_q, p_q, a_d, p_d);
          else if (aaa == 3'd4) begin a_d = x_q; p_d[7] = x_q[7]; p_d[1] = x_q == 8'd0; end
          else if (aaa == 3'd5) begin x_d = a_q; p_d[7] = a_q[7]; p_d[1] = a_q == 8'd0; end
          else if (aaa == 3'd6) begin
            x_d = x_q - 8'd1; p_d[7] = x_d[7]; p_d[1] = x_d == 8'd0;
          end
        end else if (bbb == 3'd6) begin
          if (aaa == 3'd4) sp_d = x_q;
          else if (aaa == 3'd5) begin x_d = sp_q; p_d[7] = sp_q[7]; p_d[1] = sp_q == 8'd0; end
        end else begin
          if (!aaa[2]) begin wr = 1'b1; shift(aaa[1:0], m, p_q, wd, p_d); end
          else if (aaa == 3'd4) begin wr = 1'b1; wd = (bbb == 3'd7) ? (x_q & hp1) : x_q; end
          else if (aaa == 3'd5) begin x_d = m; p_d[7] = m[7]; p_d[1] = m == 8'd0; end
          else begin
            wr = 1'b1; wd = (aaa == 3'd6) ? m - 8'd1 : m + 8'd1;
            p_d[7] = wd[7]; p_d[1] = wd == 8'd0;
          end
        end
      end
      default: begin
        if (bbb == 3'd2) begin
          r = a_q & m;
          unique case (aaa)
            3'd0, 3'd1: begin
              a_d = r; p_d[7] = r[7]; p_d[1] = r == 8'd0; p_d[0] = r[7];
            end
            3'd2: shift(2'd2, r, p_q, a_d, p_d);
            3'd3: begin
              v = {p_q[0], r[7:1]};
              a_d = v; p_d[7] = v[7]; p_d[1] = v == 8'd0; p_d[0] = v[6]; p_d[6] = v[6] ^ v[5];
            end
            3'd4: begin
              v = (a_q | magic_q) & x_q & m; a_d = v; p_d[7] = v[7]; p_d[1] = v == 8'd0;
            end
            3'd5: begin
              v = (a_q | magic_q) & m; a_d = v; x_d = v; p_d[7] = v[7]; p_d[1] = v == 8'd0;
            end
            3'd6: begin
              v = a_q & x_q; x_d = v - m; p_d[0] = v >= m;
              p_d[7] = x_d[7]; p_d[1] = x_d == 8'd0;
            end
            default: alu(3'd7, m, a_q, p_q, a_d, p_d);
          endcase
        end else if (!aaa[2]) begin
          wr = 1'b1;
          shift(aaa[1:0], m, p_q, wd, v);
          alu(aaa, wd, a_q, v, a_d, p_d);
        end else if (aaa == 3'd4) begin
          wr = 1'b1;
          if (bbb == 3'd6) begin sp_d = a_q & x_q; wd = sp_d & hp1; end
          else if (bbb == 3'd4 || bbb == 3'd7) wd = a_q & x_q & hp1;
          else wd = a_q & x_q;
        end else if (aaa == 3'd5) begin
          v = (bbb == 3'd6) ? (m & sp_q) : m;
          if (bbb == 3'd6) sp_d = v;
          a_d = v; x_d = v; p_d[7] = v[7]; p_d[1] = v == 8'd0;
        end else if (aaa == 3'd6) begin
          wr = 1'b1; wd = m - 8'd1; r = a_q - wd;
          p_d[0] = a_q >= wd; p_d[7] = r[7]; p_d[1] = r == 8'd0;
        end else begin
          wr = 1'b1; wd = m + 8'd1;
          alu(3'd7, wd, a_q, p_q, a_d, p_d);
        end
      end
    endcase
    p_d = (p_d & ~FLAG_B) | FLAG_U;
  end

  // Commit registers and the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0;
      sp_q <= RESET_SP; p_q <= RESET_STATUS; magic_q <= RESET_MAGIC;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) magic_q <= cfg_wdata_i;
      if (fire) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
      end
      if (dec_ready_o) out_valid_q <= dec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.acc_out      <= a_d;
      out_q.x_out        <= x_d;
      out_q.y_out        <= y_d;
      out_q.sp_out       <= sp_d;
      out_q.status_out   <= p_d;
      out_q.mem_write    <= wr;
      out_q.write_data   <= wr ? wd : 8'd0;
      out_q.branch_taken <= br;
    end
  end

  `CPU8_ASSERT(a_status_u, out_valid_q |-> (out_q.status_out[5] && !out_q.status_out[4]), "status bits 5/4 wrong")
  `CPU8_ASSERT(a_hold, (out_valid_q && !res_ready_i) |=> $stable(out_q), "result changed while stalled")
  `CPU8_ASSERT(a_wd_zero, (out_valid_q && !out_q.mem_write) |-> out_q.write_data == 8'd0, "write data without write")
  `CPU8_ASSERT_RST(a_rst, $rose(rst_ni) |-> !out_valid_q, "result valid out of reset")
endmodule

>>> rtl/cpu8_register_alu_execute.sv
// Top level of the 8-bit processor execute block
// Usage:
//   in_if carries one instruction transaction: opcode, operand (fetched byte
//   or pulled stack byte) and address_high. out_if carries one result
//   transaction per instruction: A, X, Y, SP, status, memory write strobe and
//   byte, and the branch flag. Both are valid/ready channels.
//   cfg_we_i/cfg_wdata_i write the unstable mask used by ANE and LXA; write
//   only while no instruction is in flight.
// Path: an accepted instruction passes through the decode register, the
//   two-entry queue and the execute output register before its result is
//   valid; the result then holds there until out_if takes it.
// Throughput: one instruction per cycle unless out_if stalls; the execute step
//   reads and writes the register file in the same cycle, which sets that rate.
// Reset: A=X=Y=0, SP=0xFD, status=0x24, mask=0xEE, all channels empty.
// Stall: when out_if is not taken, the output holds, the queue fills and
//   then in_if.ready falls; nothing is lost.
module cpu8_register_alu_execute
  import cpu8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  cpu8_stream_if.sink   in_if,
  cpu8_stream_if.source out_if
);
  logic dec_valid, dec_ready, q_valid, q_ready;
  dec_t dec_data, q_data;

  cpu8_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready), .in_data_i (in_if.data),
    .dec_valid_o (dec_valid), .dec_ready_i (dec_ready), .dec_data_o (dec_data)
  );

  cpu8_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (dec_valid), .wr_ready_o (dec_ready), .wr_data_i (dec_data),
    .rd_valid_o (q_valid), .rd_ready_i (q_ready), .rd_data_o (q_data)
  );

  cpu8_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .dec_valid_i (q_valid), .dec_ready_o (q_ready), .dec_data_i (q_data),
    .res_valid_o (out_if.valid), .res_ready_i (out_if.ready), .res_data_o (out_if.data)
  );
endmodule

>>> dv/cpu8_register_alu_execute_tb.sv
// Self-checking testbench for the 8-bit processor execute block
module cpu8_register_alu_execute_tb;
  import cpu8_pkg::*;

  // Predict execute results and check them in order
  class exec_scoreboard;
    logic [7:0] a, x, y, sp, p, magic;
    result_t pending[$];
    int errors;
    int checked;

    function new();
      a = 8'h00; x = 8'h00; y = 8'h00;
      sp = RESET_SP; p = RESET_STATUS; magic = RESET_MAGIC;
      errors = 0; checked = 0;
    endfunction

    function void set_flag(logic [7:0] mask, bit on);
      p = on ? (p | mask) : (p & ~mask);
    endfunction

    function void set_nz(logic [7:0] v);
      set_flag(FLAG_N, v[7]);
      set_flag(FLAG_Z, v == 8'h00);
    endfunction

    function void add_carry(logic [7:0] v);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, v} + {8'h00, p[0]};
      set_flag(FLAG_C, s[8]);
      set_flag(FLAG_V, ((a ^ s[7:0]) & (v ^ s[7:0]) & 8'h80) != 0);
      a = s[7:0];
      set_nz(a);
    endfunction

    function void compare(logic [7:0] r, logic [7:0] v);
      set_flag(FLAG_C, r >= v);
      set_nz(r - v);
    endfunction

    // kind 0 ASL, 1 ROL, 2 LSR, 3 ROR
    function logic [7:0] shift_op(int kind, logic [7:0] v);
      logic [7:0] r;
      logic cin;
      cin = p[0];
      case (kind)
        0: begin r = v << 1; set_flag(FLAG_C, v[7]); end
        1: begin r = {v[6:0], cin}; set_flag(FLAG_C, v[7]); end
        2: begin r = v >> 1; set_flag(FLAG_C, v[0]); end
        default: begin r = {cin, v[7:1]}; set_flag(FLAG_C, v[0]); end
      endcase
      set_nz(r);
      return r;
    endfunction

    function void alu_op(int kind, logic [7:0] v);
      case (kind)
        0: begin a = a | v; set_nz(a); end
        1: begin a = a & v; set_nz(a); end
        2: begin a = a ^ v; set_nz(a); end
        3: add_carry(v);
        5: begin a = v; set_nz(a); end
        6: compare(a, v);
        7: add_carry(~v);
        default: ;
      endcase
    endfunction

    // Note an accepted instruction and queue its expected result
    function void note_insn(insn_t t);
      logic [1:0] cc;
      int aaa, bbb;
      logic [7:0] m, hp1, wd, r;
      bit wr, br, plain, fset;
      result_t e;
      cc = t.opcode[1:0]; aaa = t.opcode[7:5]; bbb = t.opcode[4:2];
      m = t.operand; hp1 = t.address_high + 8'd1;
      wr = 0; br = 0; wd = 8'h00;
      if (cc == CC_CTRL) begin
        if (bbb == 4) begin
          case ((aaa >> 1) & 3)
            0: fset = p[7];
            1: fset = p[6];
            2: fset = p[0];
            default: fset = p[1];
          endcase
          br = (fset == aaa[0]);
        end else if (bbb == 6) begin
          case (aaa)
            0: set_flag(FLAG_C, 0);
            1: set_flag(FLAG_C, 1);
            2: set_flag(FLAG_I, 0);
            3: set_flag(FLAG_I, 1);
            4: begin a = y; set_nz(a); end
            5: set_flag(FLAG_V, 0);
            6: set_flag(FLAG_D, 0);
            default: set_flag(FLAG_D, 1);
          endcase
        end else if (bbb == 2) begin
          case (aaa)
            0: begin wr = 1; wd = p | FLAG_B | FLAG_U; sp = sp - 8'd1; end
            1: begin sp = sp + 8'd1; p = (m & 8'hCF) | FLAG_U; end
            2: begin wr = 1; wd = a; sp = sp - 8'd1; end
            3: begin sp = sp + 8'd1; a = m; set_nz(m); end
            4: begin y = y - 8'd1; set_nz(y); end
            5: begin y = a; set_nz(y); end
            6: begin y = y + 8'd1; set_nz(y); end
            default: begin x = x + 8'd1; set_nz(x); end
          endcase
        end else if (bbb == 0) begin
          case (aaa)
            0: begin sp = sp - 8'd3; set_flag(FLAG_I, 1); end
            1: sp = sp - 8'd2;
            2: begin sp = sp + 8'd3; p = (m & 8'hCF) | FLAG_U; end
            3: sp = sp + 8'd2;
            5: begin y = m; set_nz(m); end
            6: compare(y, m);
            7: compare(x, m);
            default: ;
          endcase
        end else begin
          plain = (bbb == 1 || bbb == 3);
          case (aaa)
            1: if (plain) begin
              set_flag(FLAG_Z, (a & m) == 0);
              set_flag(FLAG_N, m[7]);
              set_flag(FLAG_V, m[6]);
            end
            4: begin wr = 1; wd = (bbb == 7) ? (y & hp1) : y; end
            5: begin y = m; set_nz(m); end
            6: if (plain) compare(y, m);
            7: if (plain) compare(x, m);
            default: ;
          endcase
        end
      end else if (cc == CC_ALU) begin
        if (aaa == 4) begin
          if (bbb != 2) begin wr = 1; wd = a; end
        end else alu_op(aaa, m);
      end else if (cc == CC_RMW) begin
        if (bbb == 4 || (bbb == 0 && aaa < 4)) begin
          // jam: hold everything
        end else if (bbb == 0) begin
          if (aaa == 5) begin x = m; set_nz(m); end
        end else if (bbb == 2) begin
          if (aaa < 4) a = shift_op(aaa, a);
          else if (aaa == 4) begin a = x; set_nz(a); end
          else if (aaa == 5) begin x = a; set_nz(x); end
          else if (aaa == 6) begin x = x - 8'd1; set_nz(x); end
        end else if (bbb == 6) begin
          if (aaa == 4) sp = x;
          else if (aaa == 5) begin x = sp; set_nz(x); end
        end else begin
          if (aaa < 4) begin wr = 1; wd = shift_op(aaa, m); end
          else if (aaa == 4) begin wr = 1; wd = (bbb == 7) ? (x & hp1) : x; end
          else if (aaa == 5) begin x = m; set_nz(m); end
          else if (aaa == 6) begin wr = 1; wd = m - 8'd1; set_nz(wd); end
          else begin wr = 1; wd = m + 8'd1; set_nz(wd); end
        end
      end else begin
        if (bbb == 2) begin
          case (aaa)
            0, 1: begin a = a & m; set_nz(a); set_flag(FLAG_C, a[7]); end
            2: begin a = a & m; a = shift_op(2, a); end
            3: begin
              a = a & m;
              r = {p[0], a[7:1]};
              a = r; set_nz(r);
              set_flag(FLAG_C, r[6]);
              set_flag(FLAG_V, r[6] ^ r[5]);
            end
            4: begin a = (a | magic) & x & m; set_nz(a); end
            5: begin a = (a | magic) & m; x = a; set_nz(a); end
            6: begin
              r = a & x;
              set_flag(FLAG_C, r >= m);
              x = r - m; set_nz(x);
            end
            default: add_carry(~m);
          endcase
        end else if (aaa < 4) begin
          wr = 1; wd = shift_op(aaa, m);
          alu_op(aaa, wd);
        end else if (aaa == 4) begin
          wr = 1;
          if (bbb == 6) begin sp = a & x; wd = sp & hp1; end
          else if (bbb == 4 || bbb == 7) wd = a & x & hp1;
          else wd = a & x;
        end else if (aaa == 5) begin
          r = (bbb == 6) ? (m & sp) : m;
          if (bbb == 6) sp = r;
          a = r; x = r; set_nz(r);
        end else if (aaa == 6) begin
          wr = 1; wd = m - 8'd1;
          compare(a, wd);
        end else begin
          wr = 1; wd = m + 8'd1;
          add_carry(~wd);
        end
      end
      p = (p & ~FLAG_B) | FLAG_U;
      e.acc_out = a; e.x_out = x; e.y_out = y; e.sp_out = sp; e.status_out = p;
      e.mem_write = wr; e.write_data = wr ? wd : 8'h00; e.branch_taken = br;
      pending.push_back(e);
    endfunction

    // Compare one result against the oldest expectation
    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got !== e) begin
        $display("%0t: mismatch expected A=%h X=%h Y=%h SP=%h P=%h W=%b D=%h B=%b",
                 $time, e.acc_out, e.x_out, e.y_out, e.sp_out, e.status_out,
                 e.mem_write, e.write_data, e.branch_taken);
        $display("%0t:          actual   A=%h X=%h Y=%h SP=%h P=%h W=%b D=%h B=%b",
                 $time, got.acc_out, got.x_out, got.y_out, got.sp_out, got.status_out,
                 got.mem_write, got.write_data, got.branch_taken);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [7:0] cfg_wdata_i = 8'h00;
  int send_idle = 0;
  int recv_idle = 0;
  int sent = 0;
  exec_scoreboard sb = new();

  cpu8_stream_if #(.T(insn_t)) in_if ();
  cpu8_stream_if #(.T(result_t)) out_if ();

  cpu8_register_alu_execute uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_if), .out_if(out_if)
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Track transactions on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.note_insn(in_if.data);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // Receiver: stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) out_if.ready <= 0;
    else out_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Send one instruction, idling at random beforehand
  task automatic send_insn(logic [7:0] op, logic [7:0] opnd, logic [7:0] ah);
    insn_t t;
    t.opcode = op; t.operand = opnd; t.address_high = ah;
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 0;
      @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.data <= t;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_if.valid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_magic(logic [7:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    sb.magic = v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Random instruction, biased toward interesting operands
  task automatic send_random();
    logic [7:0] opnd;
    case ($urandom_range(3))
      0: opnd = 8'h00;
      1: opnd = 8'hFF;
      default: opnd = 8'($urandom_range(255));
    endcase
    send_insn(8'($urandom_range(255)), opnd, 8'($urandom_range(255)));
  endtask

  initial begin
    logic [7:0] dir_ops[$];
    in_if.valid = 0;
    in_if.data = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: arithmetic extremes, branches, stack, unstable ops, jam
    dir_ops = '{8'hA9, 8'h69, 8'h69, 8'hE9, 8'h6A, 8'h10, 8'h30, 8'h08, 8'h28, 8'h48,
                8'h68, 8'h40, 8'h00, 8'h20, 8'h60, 8'h8B, 8'hAB, 8'h9F, 8'h9B, 8'hBB,
                8'hCB, 8'h6B, 8'h24, 8'h02, 8'hF8};
    foreach (dir_ops[i])
      send_insn(dir_ops[i], (i % 2) ? 8'hFF : 8'h80, (i % 3) ? 8'hFF : 8'h00);
    write_magic(8'h00);
    for (int k = 0; k < 600; k++) begin
      if (k == 200) begin send_idle = 78; recv_idle = 21; write_magic(8'hFF); end
      else if (k == 0) begin send_idle = 21; recv_idle = 78; end
      else if (k == 400) begin
        send_idle = 0; recv_idle = 0; write_magic(8'($urandom_range(255)));
      end
      if (k == 300) drain();
      send_random();
    end
    drain();
    $display("Ran %0d instructions, checked %0d results, 4 mask settings, three idle mixes.",
             sent, sb.checked);
    if (sb.errors == 0) $display("** cpu8_register_alu_execute: PASSED **");
    else $display("** cpu8_register_alu_execute: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("** cpu8_register_alu_execute: FAILED **");
    $finish;
  end
endmodule

>>> cpu8_register_alu_execute.f
+incdir+rtl
rtl/cpu8_pkg.sv
rtl/cpu8_stream_if.sv
rtl/cpu8_front.sv
rtl/cpu8_queue.sv
rtl/cpu8_back.sv
rtl/cpu8_register_alu_execute.sv
dv/cpu8_register_alu_execute_tb.sv
